// File: hw/rtl/byte_tensor_difference_statistics_unit_macros.svh
// ----------------------------------------------------------------------------
// byte tensor difference statistics: assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BYTE_TENSOR_DIFFERENCE_STATISTICS_UNIT_MACROS_SVH
`define BYTE_TENSOR_DIFFERENCE_STATISTICS_UNIT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define BTDS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define BTDS_ASSERT_NEVER(label, clk, rst_n, bad, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) else $error(msg);
`else
`define BTDS_ASSERT(label, clk, rst_n, prop, msg)
`define BTDS_ASSERT_NEVER(label, clk, rst_n, bad, msg)
`endif

`endif

// File: hw/rtl/btds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_pkg
// shared codes, widths and controller/datapath bundles
// ----------------------------------------------------------------------------
package btds_pkg;

	localparam int BYTE_W    = 8;
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 40;
	localparam int BIN_W     = 9;
	localparam int HIST_BINS = 511;

	// transaction commands
	typedef enum logic [1:0] {
		CMD_COMPARE = 2'd0,
		CMD_READ    = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_start;
		logic clr_step;
		logic update;
		logic emit;
	} dp_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic clr_done;
		logic out_blocked;
	} dp_status_t;

endpackage

// File: hw/rtl/btds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds interfaces
// request channel (commands and element pairs) and response channel
// ----------------------------------------------------------------------------
interface btds_req_if;
	import btds_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [BYTE_W-1:0]        lhs_value;
	logic [BYTE_W-1:0]        rhs_value;
	logic                     last;
	logic signed [BIN_W-1:0]  bin_offset;

	modport source (output valid, command, lhs_value, rhs_value, last, bin_offset,
		input ready);
	modport sink (input valid, command, lhs_value, rhs_value, last, bin_offset,
		output ready);
endinterface

interface btds_rsp_if #(
	parameter int COUNT_BITS = 24
);
	import btds_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [COUNT_BITS:0]       unequal_count;
	logic signed [COUNT_BITS:0] first_mismatch;
	logic [BYTE_W-1:0]         peak_abs_diff;
	logic [SUM_W-1:0]          abs_diff_sum;
	logic [SQ_W-1:0]           sq_diff_sum;
	logic [BYTE_W-1:0]         left_min;
	logic [BYTE_W-1:0]         left_max;
	logic [SUM_W-1:0]          left_sum;
	logic [BYTE_W-1:0]         right_min;
	logic [BYTE_W-1:0]         right_max;
	logic [SUM_W-1:0]          right_sum;
	logic [COUNT_BITS:0]       bin_count;

	modport source (output valid, unequal_count, first_mismatch, peak_abs_diff,
		abs_diff_sum, sq_diff_sum, left_min, left_max, left_sum, right_min,
		right_max, right_sum, bin_count, input ready);
	modport sink (input valid, unequal_count, first_mismatch, peak_abs_diff,
		abs_diff_sum, sq_diff_sum, left_min, left_max, left_sum, right_min,
		right_max, right_sum, bin_count, output ready);
endinterface

// File: hw/rtl/btds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_ctrl
// sequencer: clearing pass, request accept, histogram lookup and update
// ----------------------------------------------------------------------------
`include "byte_tensor_difference_statistics_unit_macros.svh"

module btds_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [1:0]            req_command,
	output logic                  req_ready,
	input  btds_pkg::dp_status_t  sts,
	output btds_pkg::dp_ctrl_t    ctl
);
	import btds_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_LOOK  = 4'b0100,
		S_UPD   = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] op_q, op_d;

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		req_ready = 1'b0;
		ctl       = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					case (req_command)
						CMD_COMPARE, CMD_READ: begin
							op_d    = req_command;
							state_d = S_LOOK;
						end
						CMD_CLEAR: begin
							ctl.clr_start = 1'b1;
							state_d       = S_CLEAR;
						end
						default: ;
					endcase
				end
			end
			S_LOOK: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (op_q == CMD_COMPARE) begin
					// a pair without last never waits on the response side
					if (!(sts.last && sts.out_blocked)) begin
						ctl.update = 1'b1;
						ctl.emit   = sts.last;
						state_d    = S_IDLE;
					end
				end else begin
					if (!sts.out_blocked) begin
						ctl.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers, reset starts the histogram clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q    <= CMD_COMPARE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// checks
	`BTDS_ASSERT(a_look_then_upd, clk, arst_n, (state_q == S_LOOK) |=> (state_q == S_UPD), "lookup not followed by update")
	`BTDS_ASSERT_NEVER(a_ready_busy, clk, arst_n, req_ready && (ctl.clr_step || ctl.update || ctl.emit), "request taken while busy")

endmodule

// File: hw/rtl/btds_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_dp
// statistics registers, difference histogram memory and response register
// ----------------------------------------------------------------------------
`include "byte_tensor_difference_statistics_unit_macros.svh"

module btds_dp #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  btds_pkg::dp_ctrl_t                     ctl,
	output btds_pkg::dp_status_t                   sts,
	input  logic [1:0]                             req_command,
	input  logic [btds_pkg::BYTE_W-1:0]            req_lhs,
	input  logic [btds_pkg::BYTE_W-1:0]            req_rhs,
	input  logic                                   req_last,
	input  logic signed [btds_pkg::BIN_W-1:0]      req_offset,
	input  logic                                   rsp_ready,
	output logic                                   rsp_valid,
	output logic [COUNT_BITS:0]                    unequal_count,
	output logic signed [COUNT_BITS:0]             first_mismatch,
	output logic [btds_pkg::BYTE_W-1:0]            peak_abs_diff,
	output logic [btds_pkg::SUM_W-1:0]             abs_diff_sum,
	output logic [btds_pkg::SQ_W-1:0]              sq_diff_sum,
	output logic [btds_pkg::BYTE_W-1:0]            left_min,
	output logic [btds_pkg::BYTE_W-1:0]            left_max,
	output logic [btds_pkg::SUM_W-1:0]             left_sum,
	output logic [btds_pkg::BYTE_W-1:0]            right_min,
	output logic [btds_pkg::BYTE_W-1:0]            right_max,
	output logic [btds_pkg::SUM_W-1:0]             right_sum,
	output logic [COUNT_BITS:0]                    bin_count
);
	import btds_pkg::*;

	localparam int                 CNT_W     = COUNT_BITS + 1;
	localparam logic [CNT_W-1:0]   CNT_MAX   = {1'b1, {COUNT_BITS{1'b0}}};
	localparam logic [COUNT_BITS-1:0] IDX_MAX = {COUNT_BITS{1'b1}};
	localparam logic [BYTE_W-1:0]  BYTE_MAX  = {BYTE_W{1'b1}};
	localparam logic [BIN_W-1:0]   BIN_BIAS  = BIN_W'(255);
	localparam logic [BIN_W-1:0]   BIN_LAST  = BIN_W'(HIST_BINS - 1);
	localparam logic [BIN_W-1:0]   OFF_NONE  = {1'b1, {(BIN_W-1){1'b0}}};

	// captured transaction
	logic [BYTE_W-1:0]   lhs_q, rhs_q, ad_q;
	logic [2*BYTE_W-1:0] sq_q;
	logic                last_q, bin_ok_q;
	logic [BIN_W-1:0]    addr_q;

	// histogram memory
	logic [CNT_W-1:0]    hist_mem [HIST_BINS];
	logic [CNT_W-1:0]    rd_q, wr_data;
	logic                wr_en;

	// statistics
	logic [COUNT_BITS-1:0]   idx_q, idx_nx;
	logic [CNT_W-1:0]        mis_q, mis_nx;
	logic signed [CNT_W-1:0] first_q, first_nx;
	logic [BYTE_W-1:0]       maxd_q, maxd_nx;
	logic [SUM_W-1:0]        abs_q, abs_nx;
	logic [SQ_W-1:0]         sqs_q, sqs_nx;
	logic [BYTE_W-1:0]       lmin_q, lmin_nx, lmax_q, lmax_nx;
	logic [BYTE_W-1:0]       rmin_q, rmin_nx, rmax_q, rmax_nx;
	logic [SUM_W-1:0]        lsum_q, lsum_nx, rsum_q, rsum_nx;
	logic                    any_q, any_nx;
	logic                    diff_nz;
	logic [SUM_W:0]          abs_add, lsum_add, rsum_add;
	logic [SQ_W:0]           sqs_add;

	// response register
	logic                    out_valid_q;
	logic                    out_blocked;

	// capture of the accepted pair or read request
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			lhs_q    <= req_lhs;
			rhs_q    <= req_rhs;
			last_q   <= req_last;
			ad_q     <= (req_lhs >= req_rhs) ? (req_lhs - req_rhs) : (req_rhs - req_lhs);
			bin_ok_q <= ($unsigned(req_offset) != OFF_NONE);
		end
		sq_q <= {{BYTE_W{1'b0}}, ad_q} * {{BYTE_W{1'b0}}, ad_q};
	end

	// histogram address: bin of lhs - rhs, read offset, or clearing pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (ctl.clr_start) begin
			addr_q <= '0;
		end else if (ctl.clr_step) begin
			addr_q <= addr_q + BIN_W'(1);
		end else if (ctl.accept) begin
			if (req_command == CMD_COMPARE)
				addr_q <= {1'b0, req_lhs} + {1'b0, ~req_rhs};
			else
				addr_q <= $unsigned(req_offset) + BIN_BIAS;
		end
	end

	// bin write: zero during clearing, saturating increment on update
	assign wr_en   = ctl.clr_step | ctl.update;
	assign wr_data = ctl.clr_step ? '0 : ((rd_q == CNT_MAX) ? rd_q : rd_q + CNT_W'(1));

	always_ff @(posedge clk) begin
		if (wr_en) hist_mem[addr_q] <= wr_data;
		rd_q <= hist_mem[addr_q];
	end

	// next statistics, equal to the current ones unless updating
	assign diff_nz  = (ad_q != '0);
	assign abs_add  = {1'b0, abs_q} + (SUM_W+1)'(ad_q);
	assign sqs_add  = {1'b0, sqs_q} + (SQ_W+1)'(sq_q);
	assign lsum_add = {1'b0, lsum_q} + (SUM_W+1)'(lhs_q);
	assign rsum_add = {1'b0, rsum_q} + (SUM_W+1)'(rhs_q);

	always_comb begin
		idx_nx   = idx_q;
		mis_nx   = mis_q;
		first_nx = first_q;
		maxd_nx  = maxd_q;
		abs_nx   = abs_q;
		sqs_nx   = sqs_q;
		lmin_nx  = lmin_q;
		lmax_nx  = lmax_q;
		lsum_nx  = lsum_q;
		rmin_nx  = rmin_q;
		rmax_nx  = rmax_q;
		rsum_nx  = rsum_q;
		any_nx   = any_q;
		if (ctl.update) begin
			if (idx_q != IDX_MAX) idx_nx = idx_q + COUNT_BITS'(1);
			if (diff_nz && (mis_q != CNT_MAX)) mis_nx = mis_q + CNT_W'(1);
			if (diff_nz && first_q[CNT_W-1]) first_nx = {1'b0, idx_q};
			if (ad_q > maxd_q) maxd_nx = ad_q;
			abs_nx  = abs_add[SUM_W] ? '1 : abs_add[SUM_W-1:0];
			sqs_nx  = sqs_add[SQ_W] ? '1 : sqs_add[SQ_W-1:0];
			if (lhs_q < lmin_q) lmin_nx = lhs_q;
			if (lhs_q > lmax_q) lmax_nx = lhs_q;
			lsum_nx = lsum_add[SUM_W] ? '1 : lsum_add[SUM_W-1:0];
			if (rhs_q < rmin_q) rmin_nx = rhs_q;
			if (rhs_q > rmax_q) rmax_nx = rhs_q;
			rsum_nx = rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
			any_nx  = 1'b1;
		end
	end

	// statistics registers, clear command returns them to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			mis_q   <= '0;
			first_q <= '1;
			maxd_q  <= '0;
			abs_q   <= '0;
			sqs_q   <= '0;
			lmin_q  <= BYTE_MAX;
			lmax_q  <= '0;
			lsum_q  <= '0;
			rmin_q  <= BYTE_MAX;
			rmax_q  <= '0;
			rsum_q  <= '0;
			any_q   <= 1'b0;
		end else if (ctl.clr_start) begin
			idx_q   <= '0;
			mis_q   <= '0;
			first_q <= '1;
			maxd_q  <= '0;
			abs_q   <= '0;
			sqs_q   <= '0;
			lmin_q  <= BYTE_MAX;
			lmax_q  <= '0;
			lsum_q  <= '0;
			rmin_q  <= BYTE_MAX;
			rmax_q  <= '0;
			rsum_q  <= '0;
			any_q   <= 1'b0;
		end else begin
			idx_q   <= idx_nx;
			mis_q   <= mis_nx;
			first_q <= first_nx;
			maxd_q  <= maxd_nx;
			abs_q   <= abs_nx;
			sqs_q   <= sqs_nx;
			lmin_q  <= lmin_nx;
			lmax_q  <= lmax_nx;
			lsum_q  <= lsum_nx;
			rmin_q  <= rmin_nx;
			rmax_q  <= rmax_nx;
			rsum_q  <= rsum_nx;
			any_q   <= any_nx;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit)
			out_valid_q <= 1'b1;
		else if (rsp_ready)
			out_valid_q <= 1'b0;
	end

	// response payload, bin count only on a read of a real bin
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			unequal_count  <= mis_nx;
			first_mismatch <= first_nx;
			peak_abs_diff  <= maxd_nx;
			abs_diff_sum   <= abs_nx;
			sq_diff_sum    <= sqs_nx;
			left_min       <= any_nx ? lmin_nx : '0;
			left_max       <= any_nx ? lmax_nx : '0;
			left_sum       <= lsum_nx;
			right_min      <= any_nx ? rmin_nx : '0;
			right_max      <= any_nx ? rmax_nx : '0;
			right_sum      <= rsum_nx;
			bin_count      <= (!ctl.update && bin_ok_q) ? rd_q : '0;
		end
	end

	assign out_blocked     = out_valid_q & ~rsp_ready;
	assign rsp_valid       = out_valid_q;
	assign sts.last        = last_q;
	assign sts.clr_done    = (addr_q == BIN_LAST);
	assign sts.out_blocked = out_blocked;

	// checks
	`BTDS_ASSERT_NEVER(a_emit_blocked, clk, arst_n, ctl.emit && out_blocked, "pending response overwritten")
	`BTDS_ASSERT(a_rsp_hold, clk, arst_n, out_blocked |=> (out_valid_q && $stable(bin_count)), "stalled response changed")
	`BTDS_ASSERT_NEVER(a_mis_sat, clk, arst_n, mis_q > CNT_MAX, "mismatch count above saturation")
	`BTDS_ASSERT_NEVER(a_clr_excl, clk, arst_n, ctl.clr_step && (ctl.update || ctl.accept), "histogram used during clearing pass")

endmodule

// File: hw/rtl/byte_tensor_difference_statistics_unit.sv
// ----------------------------------------------------------------------------
// byte tensor difference statistics unit
// one transaction at a time: a compare or read is accepted in idle, then passes
// the lookup and update states; the result of a read or last compare is registered
// in the update state, which waits while a pending response is not taken; a clear
// walks the histogram one bin per cycle, zeroing each bin; the single-port
// histogram read-modify-write and the clearing walk set this sequence
// after reset a clearing pass runs before the first request
`timescale 1ns / 1ps

module byte_tensor_difference_statistics_unit #(
	parameter int COUNT_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	btds_req_if.sink      req,
	btds_rsp_if.source    rsp
);
	import btds_pkg::*;

	dp_ctrl_t   ctl;
	dp_status_t sts;

	// sequencer
	btds_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.sts         (sts),
		.ctl         (ctl)
	);

	// statistics and histogram
	btds_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.req_command    (req.command),
		.req_lhs        (req.lhs_value),
		.req_rhs        (req.rhs_value),
		.req_last       (req.last),
		.req_offset     (req.bin_offset),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.unequal_count  (rsp.unequal_count),
		.first_mismatch (rsp.first_mismatch),
		.peak_abs_diff  (rsp.peak_abs_diff),
		.abs_diff_sum   (rsp.abs_diff_sum),
		.sq_diff_sum    (rsp.sq_diff_sum),
		.left_min       (rsp.left_min),
		.left_max       (rsp.left_max),
		.left_sum       (rsp.left_sum),
		.right_min      (rsp.right_min),
		.right_max      (rsp.right_max),
		.right_sum      (rsp.right_sum),
		.bin_count      (rsp.bin_count)
	);

endmodule
